>>> rtl/sno_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the segment normal offset block.
package sno_pkg;

    // Width of the offset distance register (unsigned fixed point).
    localparam int ROAD_WIDTH_W = 31;

endpackage

>>> rtl/segment_normal_offset.sv
`timescale 1ns / 1ps
// Top level: offsets a point along the exact unit normal of a 2D segment.

// The block takes one beat per clock while the output is not stalled and
// returns one beat per input beat, in order. Most of the pipeline stages
// are in the two bit-per-stage units in each of the
// two lanes: a restoring divider producing one quotient bit per stage
// (2*ROAD_WIDTH_W + 2 stages) and a restoring square root producing one root
// bit per stage (ROAD_WIDTH_W + 1 stages). Five more stages hold the
// differences, the products, the partial products of their squares, the
// divider load and the output register. When the output is stalled the
// whole pipeline holds, and s_axis_tready drops only while a finished beat
// waits at the output. road_width may be written only while the pipeline is
// empty; it resets to 1.0 in the fixed point format.
module segment_normal_offset #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // a_x, a_z, b_x, b_z, p_x, p_z from bit 0 up, zero padded to bytes
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // first_x, first_z, second_x, second_z from bit 0 up, zero padded to bytes
    output logic [((4*COORD_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    input  logic                                   cfg_we,
    input  logic [sno_pkg::ROAD_WIDTH_W-1:0]       cfg_wdata
);

    localparam int CW   = COORD_WIDTH;
    localparam int WW   = sno_pkg::ROAD_WIDTH_W;
    localparam int DW   = CW + 1;
    localparam int PW   = WW + DW;
    localparam int PL   = PW / 2;
    localparam int PU   = PW - PL;
    localparam int NW   = 2*PW + 2;
    localparam int LW   = 2*DW + 1;
    localparam int QW   = 2*WW + 2;
    localparam int SW   = QW / 2;
    localparam int EW   = ((CW > WW) ? CW : WW + 1) + 2;
    localparam int IN_TW  = ((6*CW+7)/8)*8;
    localparam int OUT_TW = ((4*CW+7)/8)*8;
    localparam int NST  = 5 + QW + SW;
    localparam logic [WW-1:0] RW_RESET = WW'(1) << FRAC_BITS;

    typedef struct packed {
        logic                 horiz;
        logic                 vert;
        logic                 dx_pos;
        logic                 dz_neg;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] pz;
    } side_t;

    logic [WW-1:0] road_width_reg;
    logic          vld_reg [NST];
    side_t         side_reg [NST-1];
    logic          en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            road_width_reg <= RW_RESET;
        end
        else if (cfg_we)
        begin
            road_width_reg <= cfg_wdata;
        end
    end

    assign en            = !vld_reg[NST-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < NST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Stage 1: differences and their magnitudes.
    logic signed [CW-1:0] in_ax, in_az, in_bx, in_bz;
    logic signed [DW-1:0] dx, dz;
    logic [DW-1:0]        ux_reg, uz_reg;
    side_t                side_next;

    assign in_ax = s_axis_tdata[0*CW +: CW];
    assign in_az = s_axis_tdata[1*CW +: CW];
    assign in_bx = s_axis_tdata[2*CW +: CW];
    assign in_bz = s_axis_tdata[3*CW +: CW];
    assign dx    = DW'(in_bx) - DW'(in_ax);
    assign dz    = DW'(in_bz) - DW'(in_az);

    always_comb
    begin
        side_next.horiz  = (in_az == in_bz);
        side_next.vert   = (in_ax == in_bx);
        side_next.dx_pos = !dx[DW-1] && (dx != '0);
        side_next.dz_neg = dz[DW-1];
        side_next.px     = s_axis_tdata[4*CW +: CW];
        side_next.pz     = s_axis_tdata[5*CW +: CW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg      <= dx[DW-1] ? DW'(-dx) : DW'(dx);
            uz_reg      <= dz[DW-1] ? DW'(-dz) : DW'(dz);
            side_reg[0] <= side_next;
            for (int i = 1; i < NST-1; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Stage 2: products. Lane 0 yields the x part of the normal, lane 1 the z part.
    logic [PW-1:0]   prod_reg [2];
    logic [2*DW-1:0] sqx_reg, sqz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= PW'(road_width_reg) * PW'(uz_reg);
            prod_reg[1] <= PW'(road_width_reg) * PW'(ux_reg);
            sqx_reg     <= (2*DW)'(ux_reg) * (2*DW)'(ux_reg);
            sqz_reg     <= (2*DW)'(uz_reg) * (2*DW)'(uz_reg);
        end
    end

    // Stage 3: each product is squared from half-width partial products,
    // which are summed on the way into the divider.
    logic [2*PU-1:0]  pp_hh_reg [2];
    logic [PU+PL-1:0] pp_hl_reg [2];
    logic [2*PL-1:0]  pp_ll_reg [2];
    logic [LW-1:0]    len_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 2; i++)
            begin
                pp_hh_reg[i] <= (2*PU)'(prod_reg[i][PW-1:PL]) * (2*PU)'(prod_reg[i][PW-1:PL]);
                pp_hl_reg[i] <= (PU+PL)'(prod_reg[i][PW-1:PL]) * (PU+PL)'(prod_reg[i][PL-1:0]);
                pp_ll_reg[i] <= (2*PL)'(prod_reg[i][PL-1:0]) * (2*PL)'(prod_reg[i][PL-1:0]);
            end
            len_reg <= LW'(sqx_reg) + LW'(sqz_reg);
        end
    end

    // Stage 4 loads the dividers with 4*(w*num)^2 over the squared length.
    logic [LW-1:0] dlen_reg [QW+1];
    logic [LW-1:0] drem_reg [2][QW+1];
    logic [QW-1:0] dnlo_reg [2][QW+1];
    logic [QW-1:0] dq_reg   [2][QW+1];
    logic [SW+1:0] srem_reg [2][SW+1];
    logic [SW-1:0] sroot_reg[2][SW+1];
    logic [QW-1:0] sval_reg [2][SW+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dlen_reg[0] <= len_reg;
            for (int i = 1; i <= QW; i++)
            begin
                dlen_reg[i] <= dlen_reg[i-1];
            end
        end
    end

    genvar ln, k;
    generate
        for (ln = 0; ln < 2; ln++)
        begin : g_lane
            logic [NW-1:0] num;
            assign num = {((2*PW)'(pp_hh_reg[ln]) << (2*PL))
                          + ((2*PW)'(pp_hl_reg[ln]) << (PL + 1))
                          + (2*PW)'(pp_ll_reg[ln]), 2'b00};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    drem_reg[ln][0] <= LW'(num[NW-1:QW]);
                    dnlo_reg[ln][0] <= num[QW-1:0];
                    dq_reg[ln][0]   <= '0;
                end
            end

            // Restoring divider, one quotient bit per stage.
            for (k = 1; k <= QW; k++)
            begin : g_div
                logic [LW:0] t;
                logic        ge;
                assign t  = {drem_reg[ln][k-1], dnlo_reg[ln][k-1][QW-1]};
                assign ge = (t >= (LW+1)'(dlen_reg[k-1]));

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        drem_reg[ln][k] <= ge ? LW'(t - (LW+1)'(dlen_reg[k-1])) : LW'(t);
                        dnlo_reg[ln][k] <= dnlo_reg[ln][k-1] << 1;
                        dq_reg[ln][k]   <= {dq_reg[ln][k-1][QW-2:0], ge};
                    end
                end
            end

            assign srem_reg[ln][0]  = '0;
            assign sroot_reg[ln][0] = '0;
            assign sval_reg[ln][0]  = dq_reg[ln][QW];

            // Restoring square root, one root bit per stage.
            for (k = 1; k <= SW; k++)
            begin : g_sqrt
                logic [SW+3:0] t;
                logic [SW+3:0] trial;
                logic          ge;
                assign t     = {srem_reg[ln][k-1], sval_reg[ln][k-1][QW-1 -: 2]};
                assign trial = {2'b00, sroot_reg[ln][k-1], 2'b01};
                assign ge    = (t >= trial);

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        srem_reg[ln][k]  <= ge ? (SW+2)'(t - trial) : (SW+2)'(t);
                        sroot_reg[ln][k] <= {sroot_reg[ln][k-1][SW-2:0], ge};
                        sval_reg[ln][k]  <= sval_reg[ln][k-1] << 2;
                    end
                end
            end
        end
    endgenerate

    // Final stage: the largest odd k with k*k <= floor(T) gives the rounded
    // magnitude (k+1)/2, then signs, sums and saturation.
    side_t                sd;
    logic [SW:0]          rx1, rz1;
    logic signed [EW-1:0] mx, mz, gx, gz, ex, ez, wv;
    logic signed [EW-1:0] fx, fz, sx, sz;
    logic signed [EW-1:0] sat_hi, sat_lo;
    logic [CW-1:0]        ofx, ofz, osx, osz;
    logic [OUT_TW-1:0]    out_data_reg;

    function automatic logic [CW-1:0] sat_fn(input logic signed [EW-1:0] v,
                                             input logic signed [EW-1:0] hi,
                                             input logic signed [EW-1:0] lo);
        logic [CW-1:0] r;
        if (v > hi)
        begin
            r = hi[CW-1:0];
        end
        else if (v < lo)
        begin
            r = lo[CW-1:0];
        end
        else
        begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    assign sd     = side_reg[NST-2];
    assign rx1    = (SW+1)'(sroot_reg[0][SW]) + (SW+1)'(1);
    assign rz1    = (SW+1)'(sroot_reg[1][SW]) + (SW+1)'(1);
    assign mx     = EW'(rx1[WW:1]);
    assign mz     = EW'(rz1[WW:1]);
    assign wv     = EW'(road_width_reg);
    assign sat_hi = EW'({1'b0, {(CW-1){1'b1}}});
    assign sat_lo = -sat_hi - EW'(1);

    always_comb
    begin
        gx = sd.dz_neg ? -mx : mx;
        gz = sd.dx_pos ? -mz : mz;
        if (sd.horiz)
        begin
            ex = '0;
            ez = -wv;
        end
        else if (sd.vert)
        begin
            ex = -wv;
            ez = '0;
        end
        else if (gx < 0 || (gx == 0 && gz < 0))
        begin
            ex = -gx;
            ez = -gz;
        end
        else
        begin
            ex = gx;
            ez = gz;
        end
        fx = EW'(sd.px) - ex;
        fz = EW'(sd.pz) - ez;
        sx = EW'(sd.px) + ex;
        sz = EW'(sd.pz) + ez;
    end

    assign ofx = sat_fn(fx, sat_hi, sat_lo);
    assign ofz = sat_fn(fz, sat_hi, sat_lo);
    assign osx = sat_fn(sx, sat_hi, sat_lo);
    assign osz = sat_fn(sz, sat_hi, sat_lo);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= OUT_TW'({osz, osx, ofz, ofx});
        end
    end

    assign m_axis_tdata = out_data_reg;

    logic unused_pad;
    assign unused_pad = ^s_axis_tdata[IN_TW-1:0];

endmodule

>>> bench/segment_normal_offset_tb.sv
`timescale 1ns / 1ps
// Testbench for segment_normal_offset: directed and random segments checked against a predictor.
module segment_normal_offset_tb;

    localparam int CW = 32;
    localparam int WW = sno_pkg::ROAD_WIDTH_W;
    localparam logic [WW-1:0] WIDTH_MAX = {WW{1'b1}};
    localparam logic signed [CW-1:0] C_MAX = 32'sh7fffffff;
    localparam logic signed [CW-1:0] C_MIN = 32'sh80000000;

    typedef struct packed {
        logic signed [CW-1:0] second_z;
        logic signed [CW-1:0] second_x;
        logic signed [CW-1:0] first_z;
        logic signed [CW-1:0] first_x;
    } offset_pair_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // a_x, a_z, b_x, b_z, p_x, p_z from bit 0 up
    logic [6*CW-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    // first_x, first_z, second_x, second_z from bit 0 up
    logic [4*CW-1:0] m_axis_tdata;
    logic cfg_we;
    logic [WW-1:0] cfg_wdata;

    logic [WW-1:0] width_model;
    offset_pair_t pending_offsets[$];
    int errors;
    bit no_idle;
    int hold_off_cycles;

    segment_normal_offset DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("segment_normal_offset verification failed");
        $finish;
    end

    function automatic logic signed [CW-1:0] clamp(input longint v);
        if (v > longint'(C_MAX))
            return C_MAX;
        if (v < longint'(C_MIN))
            return C_MIN;
        return CW'(v);
    endfunction

    // round(w * num / sqrt(len2)) with ties away from zero, found by bisection on
    // (2q - 1)^2 * len2 <= 4 * w^2 * num^2.
    function automatic longint unsigned normal_part(input longint unsigned w,
                                                    input longint unsigned num,
                                                    input logic [191:0] len2);
        logic [191:0] bound;
        logic [191:0] trial;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned odd;
        bound = 192'(4 * w * w) * 192'(num) * 192'(num);
        lo = 0;
        hi = w;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            odd = 2 * mid - 1;
            trial = 192'(odd * odd) * len2;
            if (trial <= bound)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic offset_pair_t predict_offsets(input logic signed [CW-1:0] ax,
                                                     input logic signed [CW-1:0] az,
                                                     input logic signed [CW-1:0] bx,
                                                     input logic signed [CW-1:0] bz,
                                                     input logic signed [CW-1:0] px,
                                                     input logic signed [CW-1:0] pz,
                                                     input logic [WW-1:0] wv);
        offset_pair_t r;
        longint w;
        longint dx;
        longint dz;
        longint ex;
        longint ez;
        longint unsigned ux;
        longint unsigned uz;
        logic [191:0] len2;
        w = longint'(wv);
        if (az == bz)
        begin
            r.first_x = px;
            r.first_z = clamp(longint'(pz) + w);
            r.second_x = px;
            r.second_z = clamp(longint'(pz) - w);
        end
        else if (ax == bx)
        begin
            r.first_x = clamp(longint'(px) + w);
            r.first_z = pz;
            r.second_x = clamp(longint'(px) - w);
            r.second_z = pz;
        end
        else
        begin
            dx = longint'(bx) - longint'(ax);
            dz = longint'(bz) - longint'(az);
            ux = dx < 0 ? -dx : dx;
            uz = dz < 0 ? -dz : dz;
            len2 = 192'(ux) * 192'(ux) + 192'(uz) * 192'(uz);
            // Normal direction is (dz, -dx); flip so x is positive, or z when x is zero.
            ex = longint'(normal_part(w, uz, len2));
            ez = longint'(normal_part(w, ux, len2));
            if (dz < 0)
                ex = -ex;
            if (dx > 0)
                ez = -ez;
            if (ex < 0 || (ex == 0 && ez < 0))
            begin
                ex = -ex;
                ez = -ez;
            end
            r.first_x = clamp(longint'(px) - ex);
            r.first_z = clamp(longint'(pz) - ez);
            r.second_x = clamp(longint'(px) + ex);
            r.second_z = clamp(longint'(pz) + ez);
        end
        return r;
    endfunction

    task automatic send_segment(input logic signed [CW-1:0] ax, input logic signed [CW-1:0] az,
                                input logic signed [CW-1:0] bx, input logic signed [CW-1:0] bz,
                                input logic signed [CW-1:0] px, input logic signed [CW-1:0] pz);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata <= {pz, px, bz, bx, az, ax};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_offsets.push_back(predict_offsets(ax, az, bx, bz, px, pz, width_model));
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_offsets.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_road_width(input logic [WW-1:0] v);
        drain_pipeline();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        width_model = v;
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return C_MAX - $urandom_range(0, 3);
            2: return C_MIN + $urandom_range(0, 3);
            3: return $signed(32'($urandom_range(0, 2000))) - 1000;
            default: return $signed($urandom) >>> $urandom_range(0, 20);
        endcase
    endfunction

    task automatic test_axis_aligned();
        send_segment(0, 0, 32'sh10000, 0, 0, 0);
        send_segment(5, 7, 5, 7, -3, 9);
        send_segment(0, 0, 0, 32'sh10000, 0, 0);
        send_segment(C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        send_segment(C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN);
        send_segment(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX);
    endtask

    task automatic test_general_directed();
        send_segment(0, 0, 32'sh10000, 32'sh10000, 0, 0);
        send_segment(0, 0, -32'sh10000, 32'sh10000, 100, -100);
        send_segment(0, 0, -32'sh30000, -32'sh40000, 0, 0);
        send_segment(0, 0, 32'sh30000, -32'sh40000, 0, 0);
        // Nearly horizontal: the x part of the normal rounds to zero.
        send_segment(C_MIN, 0, C_MAX, 1, 0, 0);
        send_segment(C_MIN, 1, C_MAX, 0, 0, 0);
        // Nearly vertical: the z part rounds to zero.
        send_segment(0, C_MIN, 1, C_MAX, 0, 0);
        send_segment(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN);
        send_segment(C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX);
        send_segment(1, 2, 2, 1, 7, 7);
    endtask

    task automatic test_random(input int count);
        logic signed [CW-1:0] c[6];
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            foreach (c[k])
                c[k] = rand_coord();
            case ($urandom_range(0, 9))
                0: c[3] = c[1];
                1: c[2] = c[0];
                2:
                begin
                    c[2] = c[0];
                    c[3] = c[1];
                end
                default: ;
            endcase
            send_segment(c[0], c[1], c[2], c[3], c[4], c[5]);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_back_pressure();
        hold_off_cycles = 400;
        no_idle = 1'b1;
        for (int i = 0; i < 150; i++)
            send_segment($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        no_idle = 1'b0;
    endtask

    // Receiver: random stall before each beat, plus one long hold-off on request.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end
            else
                stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        offset_pair_t got;
        offset_pair_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_offsets.size() == 0)
            begin
                $display("%0t: unexpected beat, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_offsets.pop_front();
                if (got.first_x !== want.first_x)
                    $display("%0t: first_x expected %0d actual %0d", $time,
                             want.first_x, got.first_x);
                if (got.first_z !== want.first_z)
                    $display("%0t: first_z expected %0d actual %0d", $time,
                             want.first_z, got.first_z);
                if (got.second_x !== want.second_x)
                    $display("%0t: second_x expected %0d actual %0d", $time,
                             want.second_x, got.second_x);
                if (got.second_z !== want.second_z)
                    $display("%0t: second_z expected %0d actual %0d", $time,
                             want.second_z, got.second_z);
                if (got !== want)
                    errors++;
            end
        end
    end

    initial
    begin
        errors = 0;
        no_idle = 1'b0;
        hold_off_cycles = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        width_model = WW'(32'h10000);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_axis_aligned();
        test_general_directed();
        test_random(150);
        write_road_width(WIDTH_MAX);
        test_axis_aligned();
        test_general_directed();
        test_random(150);
        write_road_width('0);
        test_general_directed();
        test_random(80);
        write_road_width(WW'($urandom));
        test_back_pressure();
        write_road_width(WW'($urandom_range(1, 1000)));
        test_random(150);
        write_road_width(WW'($urandom));
        test_random(150);
        drain_pipeline();
        repeat (120) @(negedge clk);

        if (errors == 0 && pending_offsets.size() == 0)
            $display("segment_normal_offset verification clean");
        else
            $display("segment_normal_offset verification failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/sno_pkg.sv
rtl/segment_normal_offset.sv
bench/segment_normal_offset_tb.sv
